// ===== rtl/centred_point_rotation_xyz_macros.svh =====
// Assertion macros used by the centred point rotation pipeline.
`ifndef CENTRED_POINT_ROTATION_XYZ_MACROS_SVH
`define CENTRED_POINT_ROTATION_XYZ_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CPR_ASSERT_NOW(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("centred point rotation: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CPR_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("centred point rotation: next-cycle check failed");

`endif

// ===== rtl/cpr_xyz_pkg.sv =====
// Package: widths, register indexes, configuration bundle and the output rounding function.
package cpr_xyz_pkg;

  localparam int unsigned POS_W    = 16;
  localparam int unsigned TRIG_W   = 16;
  localparam int unsigned CTR_W    = 17;
  localparam int unsigned REG_W    = 32;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned D_W      = 19;  // 2*pos - centre
  localparam int unsigned TT_W     = 32;  // product of two trig values
  localparam int unsigned R1_W     = 36;  // first rotation
  localparam int unsigned P16_W    = 52;  // R1 times one trig value
  localparam int unsigned P32_W    = 68;  // R1 times a trig product
  localparam int unsigned DS_W     = 35;  // d times one trig value
  localparam int unsigned DT_W     = 51;  // d times a trig product
  localparam int unsigned PART_W   = 54;  // partial sums
  localparam int unsigned WIDE_W   = 72;  // full-precision result
  localparam int unsigned STAGES   = 6;

  localparam int unsigned X_SHIFT  = 29;
  localparam int unsigned YZ_SHIFT = 43;
  localparam int unsigned CTR_SHIFT = 28;
  localparam int unsigned Q_SHIFT  = 14;

  localparam logic [IDX_W-1:0] REG_TRIG_Z   = 3'd0;
  localparam logic [IDX_W-1:0] REG_TRIG_Y   = 3'd1;
  localparam logic [IDX_W-1:0] REG_TRIG_X   = 3'd2;
  localparam logic [IDX_W-1:0] REG_CENTRE_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_CENTRE_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_CENTRE_Z = 3'd5;

  localparam logic [REG_W-1:0] TRIG_RESET = 32'h4000_0000;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cz;
    logic signed [TRIG_W-1:0] sz;
    logic signed [TRIG_W-1:0] cy;
    logic signed [TRIG_W-1:0] sy;
    logic signed [TRIG_W-1:0] cx;
    logic signed [TRIG_W-1:0] sx;
    logic signed [CTR_W-1:0]  kx;
    logic signed [CTR_W-1:0]  ky;
    logic signed [CTR_W-1:0]  kz;
  } cpr_cfg_t;

  // Divide by 2^sh truncating toward zero, then clamp to signed 16 bits.
  function automatic logic signed [POS_W-1:0] trunc_sat(input logic signed [WIDE_W-1:0] v,
                                                        input int unsigned sh);
    logic        [WIDE_W-1:0] mask;
    logic signed [WIDE_W-1:0] q;
    logic signed [POS_W-1:0]  r;
    mask = (WIDE_W'(1) << sh) - WIDE_W'(1);
    q    = v >>> sh;
    if (v[WIDE_W-1] && ((v & mask) != '0)) begin
      q = q + WIDE_W'(1);
    end
    if (q > WIDE_W'(32767)) begin
      r = 16'sh7fff;
    end else if (q < -WIDE_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = q[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/cpr_xyz_pipe.sv =====
// Six-stage rotation pipeline with per-stage valid bits and bubble-collapsing stalls.
`include "centred_point_rotation_xyz_macros.svh"

module cpr_xyz_pipe (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cpr_xyz_pkg::cpr_cfg_t                  cfg,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [cpr_xyz_pkg::POS_W-1:0]   pos_x,
  input  logic signed [cpr_xyz_pkg::POS_W-1:0]   pos_y,
  input  logic signed [cpr_xyz_pkg::POS_W-1:0]   pos_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [cpr_xyz_pkg::POS_W-1:0]   screen_x,
  output logic signed [cpr_xyz_pkg::POS_W-1:0]   screen_y,
  output logic signed [cpr_xyz_pkg::POS_W-1:0]   depth
);

  logic [cpr_xyz_pkg::STAGES-1:0] v;
  logic [cpr_xyz_pkg::STAGES:0]   rdy;

  // stage 1: centre removed, trig products
  logic signed [cpr_xyz_pkg::D_W-1:0]    s1_dx, s1_dy, s1_dz;
  logic signed [cpr_xyz_pkg::TT_W-1:0]   s1_cysx, s1_sysx, s1_sycx, s1_cycx;
  // stage 2: rotation about z, height products
  logic signed [cpr_xyz_pkg::R1_W-1:0]   s2_x1, s2_y1;
  logic signed [cpr_xyz_pkg::DS_W-1:0]   s2_dzsy;
  logic signed [cpr_xyz_pkg::DT_W-1:0]   s2_dzcysx, s2_dzcycx;
  logic signed [cpr_xyz_pkg::TT_W-1:0]   s2_sysx, s2_sycx;
  // stage 3: products of the first rotation
  logic signed [cpr_xyz_pkg::P16_W-1:0]  s3_x1cy, s3_y1cx, s3_y1sx;
  logic signed [cpr_xyz_pkg::P32_W-1:0]  s3_x1sysx, s3_x1sycx;
  logic signed [cpr_xyz_pkg::DS_W-1:0]   s3_dzsy;
  logic signed [cpr_xyz_pkg::DT_W-1:0]   s3_dzcysx, s3_dzcycx;
  // stage 4: partial sums
  logic signed [cpr_xyz_pkg::PART_W-1:0] s4_xa, s4_ya, s4_za;
  logic signed [cpr_xyz_pkg::P32_W-1:0]  s4_x1sysx, s4_x1sycx;
  // stage 5: full-precision results
  logic signed [cpr_xyz_pkg::WIDE_W-1:0] s5_xt, s5_yt, s5_zt;

  // A stage can take a word when it is empty or its successor can take its own.
  always_comb begin
    rdy[cpr_xyz_pkg::STAGES] = out_ready;
    for (int i = cpr_xyz_pkg::STAGES - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[cpr_xyz_pkg::STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < cpr_xyz_pkg::STAGES; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_dx   <= (cpr_xyz_pkg::D_W'(pos_x) <<< 1) - cpr_xyz_pkg::D_W'(cfg.kx);
      s1_dy   <= (cpr_xyz_pkg::D_W'(pos_y) <<< 1) - cpr_xyz_pkg::D_W'(cfg.ky);
      s1_dz   <= (cpr_xyz_pkg::D_W'(pos_z) <<< 1) - cpr_xyz_pkg::D_W'(cfg.kz);
      s1_cysx <= cfg.cy * cfg.sx;
      s1_sysx <= cfg.sy * cfg.sx;
      s1_sycx <= cfg.sy * cfg.cx;
      s1_cycx <= cfg.cy * cfg.cx;
    end
    if (rdy[1]) begin
      s2_x1     <= s1_dx * cfg.cz - s1_dy * cfg.sz;
      s2_y1     <= s1_dx * cfg.sz + s1_dy * cfg.cz;
      s2_dzsy   <= s1_dz * cfg.sy;
      s2_dzcysx <= s1_dz * s1_cysx;
      s2_dzcycx <= s1_dz * s1_cycx;
      s2_sysx   <= s1_sysx;
      s2_sycx   <= s1_sycx;
    end
    if (rdy[2]) begin
      s3_x1cy   <= s2_x1 * cfg.cy;
      s3_y1cx   <= s2_y1 * cfg.cx;
      s3_y1sx   <= s2_y1 * cfg.sx;
      s3_x1sysx <= s2_x1 * s2_sysx;
      s3_x1sycx <= s2_x1 * s2_sycx;
      s3_dzsy   <= s2_dzsy;
      s3_dzcysx <= s2_dzcysx;
      s3_dzcycx <= s2_dzcycx;
    end
    if (rdy[3]) begin
      s4_xa     <= (cpr_xyz_pkg::PART_W'(s3_dzsy) <<< cpr_xyz_pkg::Q_SHIFT)
                   + cpr_xyz_pkg::PART_W'(s3_x1cy);
      s4_ya     <= cpr_xyz_pkg::PART_W'(s3_y1cx) - cpr_xyz_pkg::PART_W'(s3_dzcysx);
      s4_za     <= cpr_xyz_pkg::PART_W'(s3_y1sx) + cpr_xyz_pkg::PART_W'(s3_dzcycx);
      s4_x1sysx <= s3_x1sysx;
      s4_x1sycx <= s3_x1sycx;
    end
    if (rdy[4]) begin
      s5_xt <= cpr_xyz_pkg::WIDE_W'(s4_xa)
               + (cpr_xyz_pkg::WIDE_W'(cfg.kx) <<< cpr_xyz_pkg::CTR_SHIFT);
      s5_yt <= ((cpr_xyz_pkg::WIDE_W'(s4_ya)
                 + (cpr_xyz_pkg::WIDE_W'(cfg.ky) <<< cpr_xyz_pkg::CTR_SHIFT))
                <<< cpr_xyz_pkg::Q_SHIFT) + cpr_xyz_pkg::WIDE_W'(s4_x1sysx);
      s5_zt <= (cpr_xyz_pkg::WIDE_W'(s4_za) <<< cpr_xyz_pkg::Q_SHIFT)
               - cpr_xyz_pkg::WIDE_W'(s4_x1sycx);
    end
    if (rdy[5]) begin
      screen_x <= cpr_xyz_pkg::trunc_sat(s5_xt, cpr_xyz_pkg::X_SHIFT);
      screen_y <= cpr_xyz_pkg::trunc_sat(s5_yt, cpr_xyz_pkg::YZ_SHIFT);
      depth    <= cpr_xyz_pkg::trunc_sat(s5_zt, cpr_xyz_pkg::YZ_SHIFT);
    end
  end

  `CPR_ASSERT_NEXT(a_take_lands, clk, rst, in_valid && in_ready, v[0])
  `CPR_ASSERT_NOW(a_block_only_full, clk, rst, !in_ready, (&v) && !out_ready)
  `CPR_ASSERT_NEXT(a_stall_holds_s1, clk, rst, v[0] && !rdy[1], v[0] && $stable(s1_dx))
  `CPR_ASSERT_NEXT(a_s5_moves_on, clk, rst, v[4] && rdy[5], v[5])

endmodule

// ===== rtl/centred_point_rotation_xyz.sv =====
// Top level: configuration registers and the rotation pipeline.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data    | write in
//   in      | in_valid in_ready pos_x pos_y pos_z       | word in
//   out     | out_valid out_ready screen_x screen_y depth| word out
//
// One word enters per cycle while in_ready is high; each result leaves after its word has passed every stage.
// The depth is set by the multiplier chain: trig products, first rotation, second
// products, partial sums, full-width sums, then truncation and clamping.
// Reset (synchronous) empties the pipeline and loads cos 1.0, sin 0 and centre 0.
// A stall at the output holds only the words behind it; empty stages keep filling,
// so the input is refused only when all six stages hold a word.
// Configuration writes are taken every cycle and change the registers at once.

module centred_point_rotation_xyz (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [cpr_xyz_pkg::IDX_W-1:0]              cfg_index,
  input  logic [cpr_xyz_pkg::REG_W-1:0]              cfg_data,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic signed [cpr_xyz_pkg::POS_W-1:0]       pos_x,
  input  logic signed [cpr_xyz_pkg::POS_W-1:0]       pos_y,
  input  logic signed [cpr_xyz_pkg::POS_W-1:0]       pos_z,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic signed [cpr_xyz_pkg::POS_W-1:0]       screen_x,
  output logic signed [cpr_xyz_pkg::POS_W-1:0]       screen_y,
  output logic signed [cpr_xyz_pkg::POS_W-1:0]       depth
);

  // packed trig words: cos in the upper half, sin in the lower half
  logic [cpr_xyz_pkg::REG_W-1:0] trig_z, trig_y, trig_x;
  logic [cpr_xyz_pkg::CTR_W-1:0] centre_x, centre_y, centre_z;

  cpr_xyz_pkg::cpr_cfg_t cfg;

  // the register file never back-pressures
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_z   <= cpr_xyz_pkg::TRIG_RESET;
      trig_y   <= cpr_xyz_pkg::TRIG_RESET;
      trig_x   <= cpr_xyz_pkg::TRIG_RESET;
      centre_x <= '0;
      centre_y <= '0;
      centre_z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cpr_xyz_pkg::REG_TRIG_Z:   trig_z   <= cfg_data;
        cpr_xyz_pkg::REG_TRIG_Y:   trig_y   <= cfg_data;
        cpr_xyz_pkg::REG_TRIG_X:   trig_x   <= cfg_data;
        cpr_xyz_pkg::REG_CENTRE_X: centre_x <= cfg_data[cpr_xyz_pkg::CTR_W-1:0];
        cpr_xyz_pkg::REG_CENTRE_Y: centre_y <= cfg_data[cpr_xyz_pkg::CTR_W-1:0];
        cpr_xyz_pkg::REG_CENTRE_Z: centre_z <= cfg_data[cpr_xyz_pkg::CTR_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // unpack the trig words and centres for the pipeline
  always_comb begin
    cfg.cz = trig_z[31:16];
    cfg.sz = trig_z[15:0];
    cfg.cy = trig_y[31:16];
    cfg.sy = trig_y[15:0];
    cfg.cx = trig_x[31:16];
    cfg.sx = trig_x[15:0];
    cfg.kx = centre_x;
    cfg.ky = centre_y;
    cfg.kz = centre_z;
  end

  cpr_xyz_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .screen_x  (screen_x),
    .screen_y  (screen_y),
    .depth     (depth)
  );

endmodule
